### rtl/core/kfl_pkg.sv
package kfl_pkg;

   // default sizes handed to the top level
   localparam int FRAC_BITS_DEF = 16;
   localparam int SUM_WIDTH_DEF = 48;

   // fixed field widths
   localparam int DATA_W = 32;
   localparam int VAR_W  = 31;
   localparam int HALF_W = 48;
   localparam int DIV_NW = 64;
   localparam int DIV_DW = 31;

   // ln2 in Q0.30
   localparam logic [29:0] LN2_Q30 = 30'd744261118;

   // register indexes
   localparam logic [2:0] REG_PHI   = 3'd0;
   localparam logic [2:0] REG_ALPHA = 3'd1;
   localparam logic [2:0] REG_BETA  = 3'd2;
   localparam logic [2:0] REG_OBS_A = 3'd3;
   localparam logic [2:0] REG_OBS_R = 3'd4;
   localparam logic [2:0] REG_PROC  = 3'd5;
   localparam logic [2:0] REG_DELTA = 3'd6;

   // multiplier operand selects
   localparam logic [3:0] MUL_NONE     = 4'd0;
   localparam logic [3:0] MUL_PHI_X    = 4'd1;
   localparam logic [3:0] MUL_BETA_COV = 4'd2;
   localparam logic [3:0] MUL_PHI_P    = 4'd3;
   localparam logic [3:0] MUL_T_PHI    = 4'd4;
   localparam logic [3:0] MUL_A_PP     = 4'd5;
   localparam logic [3:0] MUL_T_A      = 4'd6;
   localparam logic [3:0] MUL_A_XP     = 4'd7;
   localparam logic [3:0] MUL_PP_A     = 4'd8;
   localparam logic [3:0] MUL_K_INNOV  = 4'd9;
   localparam logic [3:0] MUL_K_A      = 4'd10;
   localparam logic [3:0] MUL_T_PP     = 4'd11;
   localparam logic [3:0] MUL_MAG_SQ   = 4'd12;
   localparam logic [3:0] MUL_M_SQ     = 4'd13;
   localparam logic [3:0] MUL_L_LN2    = 4'd14;

   // datapath actions
   localparam logic [4:0] ACT_NONE      = 5'd0;
   localparam logic [4:0] ACT_LOAD      = 5'd1;
   localparam logic [4:0] ACT_XP_PART   = 5'd2;
   localparam logic [4:0] ACT_XP        = 5'd3;
   localparam logic [4:0] ACT_T_SAT32   = 5'd4;
   localparam logic [4:0] ACT_QD        = 5'd5;
   localparam logic [4:0] ACT_PP        = 5'd6;
   localparam logic [4:0] ACT_SIG       = 5'd7;
   localparam logic [4:0] ACT_INNOV     = 5'd8;
   localparam logic [4:0] ACT_K_DIV     = 5'd9;
   localparam logic [4:0] ACT_K         = 5'd10;
   localparam logic [4:0] ACT_XF        = 5'd11;
   localparam logic [4:0] ACT_PF        = 5'd12;
   localparam logic [4:0] ACT_NOSIG     = 5'd13;
   localparam logic [4:0] ACT_TERM_DIV  = 5'd14;
   localparam logic [4:0] ACT_TERM_Q    = 5'd15;
   localparam logic [4:0] ACT_NORM      = 5'd16;
   localparam logic [4:0] ACT_LBIT      = 5'd17;
   localparam logic [4:0] ACT_LOGL      = 5'd18;
   localparam logic [4:0] ACT_LN        = 5'd19;
   localparam logic [4:0] ACT_SUM_STEP  = 5'd20;
   localparam logic [4:0] ACT_SUM_START = 5'd21;
   localparam logic [4:0] ACT_START_ERR = 5'd22;
   localparam logic [4:0] ACT_FINISH    = 5'd23;

   typedef struct packed {
      logic [3:0] mul_sel;
      logic [4:0] act;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic sig_zero;
      logic norm_done;
   } stat_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] phi;
      logic signed [DATA_W-1:0] alpha;
      logic signed [DATA_W-1:0] beta;
      logic signed [DATA_W-1:0] obs_a;
      logic [VAR_W-1:0]         obs_r;
      logic [VAR_W-1:0]         proc_q;
      logic [VAR_W-1:0]         delta;
   } cfg_type;

endpackage

### rtl/core/kfl_divider.sv
module kfl_divider
   import kfl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_NW-1:0] numer,
   input  logic [DIV_DW-1:0] denom,
   output logic              busy,
   output logic [DIV_NW-1:0] quot
);

   localparam int CNT_W = $clog2(DIV_NW + 1);

   logic [DIV_NW-1:0] q_ff, q_in;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_DW-1:0] den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [DIV_DW:0]   trial;
   logic [DIV_DW:0]   diff;

   // one quotient bit per cycle, restoring
   assign trial = {rem_ff, q_ff[DIV_NW-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         q_in    = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CNT_W'(DIV_NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[DIV_DW-1:0];
            q_in   = {q_ff[DIV_NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DW-1:0];
            q_in   = {q_ff[DIV_NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quot = q_ff;

   // a new division only starts on an idle unit
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");
   // the count runs out exactly when busy drops
   a_busy_cnt: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == CNT_W'(1)) |=> !busy_ff)
      else $error("divider busy past its last bit");
   a_idle_cnt: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == '0)
      else $error("divider count left over");

endmodule

### rtl/core/kfl_datapath.sv
module kfl_datapath
   import kfl_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int SUM_WIDTH = SUM_WIDTH_DEF
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg_i,
   input  cmd_type                  cmd_i,
   output stat_type                 stat_o,
   input  logic signed [DATA_W-1:0] req_observation,
   input  logic signed [DATA_W-1:0] req_covariate,
   input  logic signed [DATA_W-1:0] req_init_state,
   input  logic [VAR_W-1:0]         req_init_variance,
   input  logic signed [DATA_W-1:0] req_init_innovation,
   input  logic [VAR_W-1:0]         req_init_innov_variance,
   output logic signed [DATA_W-1:0] rsp_pred_state,
   output logic [VAR_W-1:0]         rsp_pred_variance,
   output logic [VAR_W-1:0]         rsp_innov_variance,
   output logic signed [DATA_W-1:0] rsp_gain,
   output logic signed [DATA_W-1:0] rsp_innovation,
   output logic signed [DATA_W-1:0] rsp_filt_state_out,
   output logic [VAR_W-1:0]         rsp_filt_variance_out,
   output logic signed [HALF_W-1:0] rsp_half_loglik,
   output logic                     rsp_variance_error
);

   localparam logic signed [67:0] S32_MAX = 68'sd2147483647;
   localparam logic signed [67:0] S32_MIN = -68'sd2147483648;
   localparam logic signed [67:0] U31_MAX = 68'sd2147483647;
   localparam logic signed [65:0] SUM_MAX = (66'sd1 <<< (SUM_WIDTH - 1)) - 66'sd1;
   localparam logic signed [65:0] SUM_MIN = -SUM_MAX - 66'sd1;
   localparam logic signed [65:0] H_MAX   = 66'sd140737488355327;
   localparam logic signed [65:0] H_MIN   = -H_MAX - 66'sd1;
   localparam logic [4:0]         LOG_TOP = 5'd30;

   function automatic logic signed [31:0] sat_s32(input logic signed [67:0] v);
      if (v > S32_MAX) begin
         return 32'sh7FFFFFFF;
      end else if (v < S32_MIN) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic [30:0] sat_u31(input logic signed [67:0] v);
      if (v < 68'sd0) begin
         return '0;
      end else if (v > U31_MAX) begin
         return 31'h7FFFFFFF;
      end
      return v[30:0];
   endfunction

   // filter state
   logic signed [31:0]          x_ff, x_in;
   logic [30:0]                 p_ff, p_in;
   logic signed [SUM_WIDTH-1:0] sum_ff, sum_in;
   // per item working values
   logic signed [31:0] y_ff, y_in, cov_ff, cov_in;
   logic signed [31:0] xp_ff, xp_in, k_ff, k_in, innov_ff, innov_in;
   logic signed [31:0] xf_ff, xf_in, t_ff, t_in, l_ff, l_in;
   logic [30:0]        pp_ff, pp_in, sig_ff, sig_in, pf_ff, pf_in;
   logic signed [67:0] acc_ff, acc_in;
   logic signed [63:0] term_ff, term_in;
   logic [31:0]        m_ff, m_in;
   logic [4:0]         e_ff, e_in;
   logic [FRAC_BITS-1:0] frac_ff, frac_in;
   logic               err_ff, err_in, kneg_ff, kneg_in;
   logic signed [65:0] prod_ff, prod_in;
   // result register
   logic signed [31:0] o_xp_ff, o_k_ff, o_innov_ff, o_xf_ff;
   logic [30:0]        o_pp_ff, o_sig_ff, o_pf_ff;
   logic signed [47:0] o_half_ff;
   logic               o_err_ff;

   logic signed [32:0] mul_a, mul_b, mag;
   logic signed [67:0] prodq;
   logic signed [65:0] pabs, lnv, sum_ext, half_ext;
   logic [33:0]        m2;
   logic               m2_hi;
   logic [30:0]        qd;
   logic signed [67:0] ks;
   logic signed [31:0] ev;
   logic signed [47:0] half;
   logic               div_start, div_busy;
   logic [DIV_NW-1:0]  div_num, div_quot;
   logic [DIV_DW-1:0]  div_den;

   assign prodq = 68'(prod_ff >>> FRAC_BITS);
   assign mag   = innov_ff < 0 ? -33'(innov_ff) : 33'(innov_ff);
   assign pabs  = prod_ff < 0 ? -prod_ff : prod_ff;
   assign lnv   = prod_ff >>> 30;
   assign m2    = prod_ff[63:30];
   assign m2_hi = |m2[33:31];
   assign qd    = (div_quot > 64'h7FFFFFFF) ? 31'h7FFFFFFF : div_quot[30:0];
   assign ks    = kneg_ff ? -$signed({4'b0, div_quot}) : $signed({4'b0, div_quot});
   assign ev    = $signed({27'b0, e_ff});

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd_i.mul_sel)
         MUL_PHI_X: begin
            mul_a = 33'(cfg_i.phi);
            mul_b = 33'(x_ff);
         end
         MUL_BETA_COV: begin
            mul_a = 33'(cfg_i.beta);
            mul_b = 33'(cov_ff);
         end
         MUL_PHI_P: begin
            mul_a = 33'(cfg_i.phi);
            mul_b = $signed({2'b0, p_ff});
         end
         MUL_T_PHI: begin
            mul_a = 33'(t_ff);
            mul_b = 33'(cfg_i.phi);
         end
         MUL_A_PP: begin
            mul_a = 33'(cfg_i.obs_a);
            mul_b = $signed({2'b0, pp_ff});
         end
         MUL_T_A: begin
            mul_a = 33'(t_ff);
            mul_b = 33'(cfg_i.obs_a);
         end
         MUL_A_XP: begin
            mul_a = 33'(cfg_i.obs_a);
            mul_b = 33'(xp_ff);
         end
         MUL_PP_A: begin
            mul_a = $signed({2'b0, pp_ff});
            mul_b = 33'(cfg_i.obs_a);
         end
         MUL_K_INNOV: begin
            mul_a = 33'(k_ff);
            mul_b = 33'(innov_ff);
         end
         MUL_K_A: begin
            mul_a = 33'(k_ff);
            mul_b = 33'(cfg_i.obs_a);
         end
         MUL_T_PP: begin
            mul_a = 33'(t_ff);
            mul_b = $signed({2'b0, pp_ff});
         end
         MUL_MAG_SQ: begin
            mul_a = mag;
            mul_b = mag;
         end
         MUL_M_SQ: begin
            mul_a = $signed({1'b0, m_ff});
            mul_b = $signed({1'b0, m_ff});
         end
         MUL_L_LN2: begin
            mul_a = 33'(l_ff);
            mul_b = $signed({3'b0, LN2_Q30});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // divider operand select
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = sig_ff;
      case (cmd_i.act)
         ACT_QD: begin
            div_start = 1'b1;
            div_num   = {33'b0, cfg_i.proc_q} << FRAC_BITS;
            div_den   = cfg_i.delta;
         end
         ACT_K_DIV: begin
            div_start = 1'b1;
            div_num   = pabs[63:0];
         end
         ACT_TERM_DIV: begin
            div_start = 1'b1;
            div_num   = prod_ff[63:0];
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   kfl_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (div_den),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   // half of the running sum, clamped to the result field
   assign half_ext = 66'(sum_ff >>> 1);
   assign half = (half_ext > H_MAX) ? H_MAX[47:0] :
                 (half_ext < H_MIN) ? H_MIN[47:0] : half_ext[47:0];

   // action decode
   always_comb begin
      x_in = x_ff;  p_in = p_ff;  sum_in = sum_ff;
      y_in = y_ff;  cov_in = cov_ff;
      xp_in = xp_ff;  k_in = k_ff;  innov_in = innov_ff;  xf_in = xf_ff;
      t_in = t_ff;  l_in = l_ff;  pp_in = pp_ff;  sig_in = sig_ff;  pf_in = pf_ff;
      acc_in = acc_ff;  term_in = term_ff;  m_in = m_ff;  e_in = e_ff;
      frac_in = frac_ff;  err_in = err_ff;  kneg_in = kneg_ff;
      sum_ext = '0;
      case (cmd_i.act)
         ACT_LOAD: begin
            y_in     = req_observation;
            cov_in   = req_covariate;
            xf_in    = req_init_state;
            pf_in    = req_init_variance;
            innov_in = req_init_innovation;
            sig_in   = req_init_innov_variance;
            xp_in    = '0;
            pp_in    = '0;
            k_in     = '0;
            err_in   = 1'b0;
         end
         ACT_XP_PART: acc_in = prodq + 68'(cfg_i.alpha);
         ACT_XP:      xp_in = sat_s32(acc_ff - prodq);
         ACT_T_SAT32: t_in = sat_s32(prodq);
         ACT_QD:      t_in = 32'(sat_u31(prodq));
         ACT_PP:      pp_in = sat_u31(68'(t_ff) + $signed({37'b0, qd}));
         ACT_SIG:     sig_in = sat_u31(prodq + $signed({37'b0, cfg_i.obs_r}));
         ACT_INNOV:   innov_in = sat_s32(68'(y_ff) - prodq);
         ACT_K_DIV:   kneg_in = prod_ff < 0;
         ACT_K:       k_in = sat_s32(ks);
         ACT_XF:      xf_in = sat_s32(68'(xp_ff) + prodq);
         ACT_PF:      pf_in = sat_u31($signed({37'b0, pp_ff}) - prodq);
         ACT_NOSIG: begin
            err_in = 1'b1;
            k_in   = '0;
            xf_in  = xp_ff;
            pf_in  = pp_ff;
         end
         ACT_TERM_Q: begin
            term_in = $signed(div_quot);
            m_in    = {1'b0, sig_ff};
            e_in    = LOG_TOP;
            frac_in = '0;
         end
         ACT_NORM: begin
            m_in = {m_ff[30:0], 1'b0};
            e_in = e_ff - 5'd1;
         end
         ACT_LBIT: begin
            m_in    = m2_hi ? m2[32:1] : m2[31:0];
            frac_in = {frac_ff[FRAC_BITS-2:0], m2_hi};
         end
         ACT_LOGL: l_in = ((ev - 32'(FRAC_BITS)) <<< FRAC_BITS) + $signed(32'(frac_ff));
         ACT_LN:   term_in = term_ff + 64'(lnv);
         ACT_SUM_STEP: begin
            sum_ext = 66'(sum_ff) + 66'(term_ff);
            sum_in  = (sum_ext > SUM_MAX) ? SUM_MAX[SUM_WIDTH-1:0] :
                      (sum_ext < SUM_MIN) ? SUM_MIN[SUM_WIDTH-1:0] :
                      sum_ext[SUM_WIDTH-1:0];
         end
         ACT_SUM_START: begin
            sum_ext = 66'(term_ff);
            sum_in  = (sum_ext > SUM_MAX) ? SUM_MAX[SUM_WIDTH-1:0] :
                      (sum_ext < SUM_MIN) ? SUM_MIN[SUM_WIDTH-1:0] :
                      sum_ext[SUM_WIDTH-1:0];
         end
         ACT_START_ERR: begin
            sum_in = '0;
            err_in = 1'b1;
         end
         ACT_FINISH: begin
            x_in = xf_ff;
            p_in = pf_ff;
         end
         default: begin
            x_in = x_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff   <= '0;
         p_ff   <= '0;
         sum_ff <= '0;
      end else begin
         x_ff   <= x_in;
         p_ff   <= p_in;
         sum_ff <= sum_in;
      end
      y_ff <= y_in;  cov_ff <= cov_in;  xp_ff <= xp_in;  k_ff <= k_in;
      innov_ff <= innov_in;  xf_ff <= xf_in;  t_ff <= t_in;  l_ff <= l_in;
      pp_ff <= pp_in;  sig_ff <= sig_in;  pf_ff <= pf_in;  acc_ff <= acc_in;
      term_ff <= term_in;  m_ff <= m_in;  e_ff <= e_in;  frac_ff <= frac_in;
      err_ff <= err_in;  kneg_ff <= kneg_in;  prod_ff <= prod_in;
      // result register
      if (cmd_i.act == ACT_FINISH) begin
         o_xp_ff    <= xp_ff;
         o_pp_ff    <= pp_ff;
         o_sig_ff   <= sig_ff;
         o_k_ff     <= k_ff;
         o_innov_ff <= innov_ff;
         o_xf_ff    <= xf_ff;
         o_pf_ff    <= pf_ff;
         o_half_ff  <= half;
         o_err_ff   <= err_ff;
      end
   end

   assign stat_o.div_busy  = div_busy;
   assign stat_o.sig_zero  = (sig_ff == '0);
   assign stat_o.norm_done = m_ff[30];

   assign rsp_pred_state        = o_xp_ff;
   assign rsp_pred_variance     = o_pp_ff;
   assign rsp_innov_variance    = o_sig_ff;
   assign rsp_gain              = o_k_ff;
   assign rsp_innovation        = o_innov_ff;
   assign rsp_filt_state_out    = o_xf_ff;
   assign rsp_filt_variance_out = o_pf_ff;
   assign rsp_half_loglik       = o_half_ff;
   assign rsp_variance_error    = o_err_ff;

endmodule

### rtl/core/kfl_controller.sv
module kfl_controller
   import kfl_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_kind,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat_i,
   output cmd_type  cmd_o
);

   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_X1   = 5'd1;
   localparam logic [4:0] ST_X2   = 5'd2;
   localparam logic [4:0] ST_X3   = 5'd3;
   localparam logic [4:0] ST_P1   = 5'd4;
   localparam logic [4:0] ST_P2   = 5'd5;
   localparam logic [4:0] ST_P3   = 5'd6;
   localparam logic [4:0] ST_P4   = 5'd7;
   localparam logic [4:0] ST_S1   = 5'd8;
   localparam logic [4:0] ST_S2   = 5'd9;
   localparam logic [4:0] ST_S3   = 5'd10;
   localparam logic [4:0] ST_S4   = 5'd11;
   localparam logic [4:0] ST_S5   = 5'd12;
   localparam logic [4:0] ST_S6   = 5'd13;
   localparam logic [4:0] ST_K1   = 5'd14;
   localparam logic [4:0] ST_K2   = 5'd15;
   localparam logic [4:0] ST_K3   = 5'd16;
   localparam logic [4:0] ST_K4   = 5'd17;
   localparam logic [4:0] ST_K5   = 5'd18;
   localparam logic [4:0] ST_K6   = 5'd19;
   localparam logic [4:0] ST_CHK  = 5'd20;
   localparam logic [4:0] ST_L1   = 5'd21;
   localparam logic [4:0] ST_L2   = 5'd22;
   localparam logic [4:0] ST_L3   = 5'd23;
   localparam logic [4:0] ST_L4   = 5'd24;
   localparam logic [4:0] ST_L5   = 5'd25;
   localparam logic [4:0] ST_L6   = 5'd26;
   localparam logic [4:0] ST_L7   = 5'd27;
   localparam logic [4:0] ST_L8   = 5'd28;
   localparam logic [4:0] ST_L9   = 5'd29;
   localparam logic [4:0] ST_L10  = 5'd30;
   localparam logic [4:0] ST_FIN  = 5'd31;

   logic [4:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             step_ff, step_in;
   logic             rvalid_ff, rvalid_in;
   logic             accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      step_in       = step_ff;
      cmd_o.mul_sel = MUL_NONE;
      cmd_o.act     = ACT_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_o.act = ACT_LOAD;
               step_in   = req_kind;
               state_in  = req_kind ? ST_X1 : ST_CHK;
            end
         end
         // prediction
         ST_X1: begin
            cmd_o.mul_sel = MUL_PHI_X;
            state_in = ST_X2;
         end
         ST_X2: begin
            cmd_o.act = ACT_XP_PART;
            cmd_o.mul_sel = MUL_BETA_COV;
            state_in = ST_X3;
         end
         ST_X3: begin
            cmd_o.act = ACT_XP;
            cmd_o.mul_sel = MUL_PHI_P;
            state_in = ST_P1;
         end
         ST_P1: begin
            cmd_o.act = ACT_T_SAT32;
            state_in = ST_P2;
         end
         ST_P2: begin
            cmd_o.mul_sel = MUL_T_PHI;
            state_in = ST_P3;
         end
         ST_P3: begin
            cmd_o.act = ACT_QD;
            state_in = ST_P4;
         end
         ST_P4: begin
            if (!stat_i.div_busy) begin
               cmd_o.act = ACT_PP;
               state_in = ST_S1;
            end
         end
         // innovation
         ST_S1: begin
            cmd_o.mul_sel = MUL_A_PP;
            state_in = ST_S2;
         end
         ST_S2: begin
            cmd_o.act = ACT_T_SAT32;
            state_in = ST_S3;
         end
         ST_S3: begin
            cmd_o.mul_sel = MUL_T_A;
            state_in = ST_S4;
         end
         ST_S4: begin
            cmd_o.act = ACT_SIG;
            cmd_o.mul_sel = MUL_A_XP;
            state_in = ST_S5;
         end
         ST_S5: begin
            cmd_o.act = ACT_INNOV;
            cmd_o.mul_sel = MUL_PP_A;
            state_in = ST_S6;
         end
         ST_S6: begin
            if (stat_i.sig_zero) begin
               cmd_o.act = ACT_NOSIG;
               state_in = ST_FIN;
            end else begin
               cmd_o.act = ACT_K_DIV;
               state_in = ST_K1;
            end
         end
         // gain and update
         ST_K1: begin
            if (!stat_i.div_busy) begin
               cmd_o.act = ACT_K;
               state_in = ST_K2;
            end
         end
         ST_K2: begin
            cmd_o.mul_sel = MUL_K_INNOV;
            state_in = ST_K3;
         end
         ST_K3: begin
            cmd_o.act = ACT_XF;
            cmd_o.mul_sel = MUL_K_A;
            state_in = ST_K4;
         end
         ST_K4: begin
            cmd_o.act = ACT_T_SAT32;
            state_in = ST_K5;
         end
         ST_K5: begin
            cmd_o.mul_sel = MUL_T_PP;
            state_in = ST_K6;
         end
         ST_K6: begin
            cmd_o.act = ACT_PF;
            state_in = ST_L1;
         end
         ST_CHK: begin
            if (stat_i.sig_zero) begin
               cmd_o.act = ACT_START_ERR;
               state_in = ST_FIN;
            end else begin
               state_in = ST_L1;
            end
         end
         // likelihood term: innov^2/sig, then ln(sig)
         ST_L1: begin
            cmd_o.mul_sel = MUL_MAG_SQ;
            state_in = ST_L2;
         end
         ST_L2: begin
            cmd_o.act = ACT_TERM_DIV;
            state_in = ST_L3;
         end
         ST_L3: begin
            if (!stat_i.div_busy) begin
               cmd_o.act = ACT_TERM_Q;
               state_in = ST_L4;
            end
         end
         ST_L4: begin
            if (stat_i.norm_done) begin
               cnt_in = '0;
               state_in = ST_L5;
            end else begin
               cmd_o.act = ACT_NORM;
            end
         end
         ST_L5: begin
            cmd_o.mul_sel = MUL_M_SQ;
            state_in = ST_L6;
         end
         ST_L6: begin
            cmd_o.act = ACT_LBIT;
            cnt_in = cnt_ff + 1'b1;
            state_in = (cnt_ff == CNT_W'(FRAC_BITS - 1)) ? ST_L7 : ST_L5;
         end
         ST_L7: begin
            cmd_o.act = ACT_LOGL;
            state_in = ST_L8;
         end
         ST_L8: begin
            cmd_o.mul_sel = MUL_L_LN2;
            state_in = ST_L9;
         end
         ST_L9: begin
            cmd_o.act = ACT_LN;
            state_in = ST_L10;
         end
         ST_L10: begin
            cmd_o.act = step_ff ? ACT_SUM_STEP : ACT_SUM_START;
            state_in = ST_FIN;
         end
         // hand the item to the result register once it is free
         ST_FIN: begin
            if (!rvalid_ff || rsp_ready) begin
               cmd_o.act = ACT_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rvalid_in = rvalid_ff;
      if (cmd_o.act == ACT_FINISH) begin
         rvalid_in = 1'b1;
      end else if (rsp_ready) begin
         rvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         step_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         step_ff   <= step_in;
         rvalid_ff <= rvalid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rvalid_ff;

   a_fin_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd_o.act == ACT_FINISH) |=> rvalid_ff)
      else $error("finished item not presented");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted item dropped");
   a_log_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_L6) |-> cnt_ff < CNT_W'(FRAC_BITS))
      else $error("log bit count overran");
   a_wait_div: assert property (@(posedge clock) disable iff (reset)
      (cmd_o.act == ACT_QD || cmd_o.act == ACT_K_DIV || cmd_o.act == ACT_TERM_DIV)
      |=> stat_i.div_busy)
      else $error("division not started");

endmodule

### rtl/core/scalar_kalman_filter_loglik_unit.sv
// Scalar Kalman filter with a Gaussian log-likelihood sum, Q16.16 signed
// by default. A start item (kind 0) loads the filtered state and variance
// and seeds the sum with ln(sig0) + innov0^2/sig0; a step item (kind 1)
// predicts, updates and adds ln(sig) + innov^2/sig, and each item returns
// one result carrying every intermediate quantity and half the running sum.
// Items are handled one at a time by a sequencer around one shared
// 33x33 multiplier and one restoring divider that retires one quotient bit
// per cycle over a 64-bit numerator. A step's time is set by its three
// divisions and the bit-by-bit log2, a start's by its one division and
// the log2; a previous result still waiting on rsp_ready holds up the
// next item. A zero innovation variance sets variance_error; a step then
// skips the update of the sum and a start clears the sum to zero.
// Configuration registers sit at byte offsets 4*i on the APB port and
// are to be written only while no item is in flight.
module scalar_kalman_filter_loglik_unit
   import kfl_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int SUM_WIDTH = SUM_WIDTH_DEF
)
(
   input  logic                     clock,
   input  logic                     reset,
   // configuration
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [4:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready,
   // request channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_kind,
   input  logic signed [DATA_W-1:0] req_observation,
   input  logic signed [DATA_W-1:0] req_covariate,
   input  logic signed [DATA_W-1:0] req_init_state,
   input  logic [VAR_W-1:0]         req_init_variance,
   input  logic signed [DATA_W-1:0] req_init_innovation,
   input  logic [VAR_W-1:0]         req_init_innov_variance,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_pred_state,
   output logic [VAR_W-1:0]         rsp_pred_variance,
   output logic [VAR_W-1:0]         rsp_innov_variance,
   output logic signed [DATA_W-1:0] rsp_gain,
   output logic signed [DATA_W-1:0] rsp_innovation,
   output logic signed [DATA_W-1:0] rsp_filt_state_out,
   output logic [VAR_W-1:0]         rsp_filt_variance_out,
   output logic signed [HALF_W-1:0] rsp_half_loglik,
   output logic                     rsp_variance_error
);

   cfg_type  cfg_ff, cfg_in;
   cmd_type  cmd;
   stat_type stat;
   logic     wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[4:2];

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_PHI:   cfg_in.phi    = pwdata;
            REG_ALPHA: cfg_in.alpha  = pwdata;
            REG_BETA:  cfg_in.beta   = pwdata;
            REG_OBS_A: cfg_in.obs_a  = pwdata;
            REG_OBS_R: cfg_in.obs_r  = pwdata[30:0];
            REG_PROC:  cfg_in.proc_q = pwdata[30:0];
            REG_DELTA: cfg_in.delta  = pwdata[30:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phi    <= 32'sd65536;
         cfg_ff.alpha  <= '0;
         cfg_ff.beta   <= '0;
         cfg_ff.obs_a  <= 32'sd65536;
         cfg_ff.obs_r  <= 31'd65536;
         cfg_ff.proc_q <= 31'd65536;
         cfg_ff.delta  <= 31'd65536;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register reads
   always_comb begin
      case (reg_idx)
         REG_PHI:   prdata = cfg_ff.phi;
         REG_ALPHA: prdata = cfg_ff.alpha;
         REG_BETA:  prdata = cfg_ff.beta;
         REG_OBS_A: prdata = cfg_ff.obs_a;
         REG_OBS_R: prdata = {1'b0, cfg_ff.obs_r};
         REG_PROC:  prdata = {1'b0, cfg_ff.proc_q};
         REG_DELTA: prdata = {1'b0, cfg_ff.delta};
         default:   prdata = '0;
      endcase
   end

   kfl_controller #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat_i    (stat),
      .cmd_o     (cmd)
   );

   kfl_datapath #(
      .FRAC_BITS (FRAC_BITS),
      .SUM_WIDTH (SUM_WIDTH)
   ) u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cfg_i                   (cfg_ff),
      .cmd_i                   (cmd),
      .stat_o                  (stat),
      .req_observation         (req_observation),
      .req_covariate           (req_covariate),
      .req_init_state          (req_init_state),
      .req_init_variance       (req_init_variance),
      .req_init_innovation     (req_init_innovation),
      .req_init_innov_variance (req_init_innov_variance),
      .rsp_pred_state          (rsp_pred_state),
      .rsp_pred_variance       (rsp_pred_variance),
      .rsp_innov_variance      (rsp_innov_variance),
      .rsp_gain                (rsp_gain),
      .rsp_innovation          (rsp_innovation),
      .rsp_filt_state_out      (rsp_filt_state_out),
      .rsp_filt_variance_out   (rsp_filt_variance_out),
      .rsp_half_loglik         (rsp_half_loglik),
      .rsp_variance_error      (rsp_variance_error)
   );

endmodule
